>>> rtl/lcdseq_pkg.sv
package lcdseq_pkg;

	// Input item opcodes.
	typedef enum logic [2:0] {
		OP_ENQ_WRITE   = 3'd0,
		OP_ENQ_WAIT    = 3'd1,
		OP_ENQ_WAIT_NB = 3'd2,
		OP_TICK        = 3'd3,
		OP_FLUSH       = 3'd4
	} lcdseq_op_t;

	// Task kinds as held in the task store.
	localparam logic [1:0] TASK_WRITE   = 2'd0;
	localparam logic [1:0] TASK_WAIT    = 2'd1;
	localparam logic [1:0] TASK_WAIT_NB = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_ACK       = 2'd0;
	localparam logic [1:0] KIND_NIBBLE    = 2'd1;
	localparam logic [1:0] KIND_TICK_DONE = 2'd2;

	// Task word: value in 15..0, instruction flag 16, two-nibble flag 17, kind 19..18.
	localparam int VALUE_W = 16;
	localparam int TASK_W  = 20;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RUN_RD,
		ST_RUN_CHK,
		ST_NIB_HI,
		ST_NIB_LO,
		ST_TICK_DONE
	} lcdseq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_in;
		logic       enq_write;
		logic       flush;
		logic       scan_start;
		logic       scan_adv;
		logic       rd_scan;
		logic       rd_head;
		logic       set_fin;
		logic       fin_val;
		logic       head_adv;
		logic       dec_write;
		logic       emit;
		logic [1:0] emit_kind;
		logic       emit_hi;
		logic       emit_drop;
		logic       emit_last;
	} lcdseq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		lcdseq_op_t op;
		logic       full;
		logic       empty;
		logic       scan_at_tail;
		logic [1:0] task_kind;
		logic       task_two;
		logic       task_zero;
		logic       busy;
		logic       out_free;
	} lcdseq_stat_t;

endpackage

>>> rtl/lcdseq_datapath.sv
module lcdseq_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcdseq_pkg::lcdseq_cmd_t  cmd,
	output lcdseq_pkg::lcdseq_stat_t stat,
	input  logic [3:0]           s_tuser,
	input  logic [23:0]          s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2:0]           m_tuser,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast
);
	import lcdseq_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	// Latched input item.
	lcdseq_op_t         op_q;
	logic               instr_q;
	logic [VALUE_W-1:0] value_q;
	logic               two_q;
	logic               busy_q;

	// Queue indices, scan pointer and end-of-tick emptiness.
	logic [IDX_W-1:0] head_q, tail_q, scan_q;
	logic             fin_empty_q;

	// Task store and its registered read port.
	logic [TASK_W-1:0] mem_q [QUEUE_DEPTH];
	logic [TASK_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  rd_addr;

	// Output register.
	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic       out_rs_q;
	logic [3:0] out_nib_q;
	logic       out_drop_q;
	logic       out_empty_q;
	logic       out_last_q;

	logic               out_free;
	logic [VALUE_W-1:0] task_value;

	assign task_value = rd_data_q[VALUE_W-1:0];
	assign out_free   = !out_valid_q || m_tready;
	assign rd_addr    = cmd.rd_scan ? scan_q : head_q;

	// Capture the input item on its transfer.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= lcdseq_op_t'(s_tuser[2:0]);
			instr_q <= s_tuser[3];
			value_q <= s_tdata[15:0];
			two_q   <= s_tdata[16];
			busy_q  <= s_tdata[17];
		end
	end

	// Head, tail, scan pointer and final emptiness flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			scan_q      <= '0;
			fin_empty_q <= 1'b1;
		end else begin
			if (cmd.enq_write) tail_q <= next_slot(tail_q);
			if (cmd.flush) begin
				head_q <= tail_q;
			end else if (cmd.head_adv) begin
				head_q <= next_slot(head_q);
			end
			if (cmd.scan_start) begin
				scan_q <= head_q;
			end else if (cmd.scan_adv) begin
				scan_q <= next_slot(scan_q);
			end
			if (cmd.set_fin) fin_empty_q <= cmd.fin_val;
		end
	end

	// Task store: one write port shared by enqueue and wait countdown, one read port.
	always_ff @(posedge clk) begin
		if (cmd.enq_write) begin
			mem_q[tail_q] <= {op_q[1:0], two_q, instr_q, value_q};
		end else if (cmd.dec_write) begin
			mem_q[head_q] <= {rd_data_q[TASK_W-1:VALUE_W], task_value - 1'b1};
		end
		if (cmd.rd_scan || cmd.rd_head) rd_data_q <= mem_q[rd_addr];
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_drop_q <= cmd.emit_drop;
			out_last_q <= cmd.emit_last;
			if (cmd.emit_kind == KIND_NIBBLE) begin
				out_rs_q  <= ~rd_data_q[VALUE_W];
				out_nib_q <= cmd.emit_hi ? task_value[7:4] : task_value[3:0];
			end else begin
				out_rs_q  <= 1'b0;
				out_nib_q <= 4'd0;
			end
			out_empty_q <= (cmd.emit_kind == KIND_ACK) ? (head_q == tail_q) : fin_empty_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.op           = op_q;
		stat.full         = (next_slot(tail_q) == head_q);
		stat.empty        = (head_q == tail_q);
		stat.scan_at_tail = (scan_q == tail_q);
		stat.task_kind    = rd_data_q[TASK_W-1:VALUE_W+2];
		stat.task_two     = rd_data_q[VALUE_W+1];
		stat.task_zero    = (task_value == '0);
		stat.busy         = busy_q;
		stat.out_free     = out_free;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_rs_q, out_kind_q};
	assign m_tdata  = {2'b00, out_empty_q, out_drop_q, out_nib_q};
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/lcdseq_ctrl.sv
module lcdseq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  lcdseq_pkg::lcdseq_stat_t stat,
	output lcdseq_pkg::lcdseq_cmd_t  cmd
);
	import lcdseq_pkg::*;

	lcdseq_state_t state_q, state_d;
	logic          drop_q;
	logic          is_enq;
	logic          stop_scan;

	assign is_enq = (stat.op == OP_ENQ_WRITE) || (stat.op == OP_ENQ_WAIT) ||
		(stat.op == OP_ENQ_WAIT_NB);

	// A pending wait or a busy display ends the tick at this task.
	assign stop_scan = ((stat.task_kind == TASK_WAIT) && !stat.task_zero) ||
		((stat.task_kind == TASK_WAIT_NB) && stat.busy);

	assign s_tready = (state_q == ST_IDLE);

	// State and drop flag registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECODE) drop_q <= is_enq && stat.full;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_DECODE;
			ST_DECODE:    state_d = (stat.op == OP_TICK) ? ST_SCAN_RD : ST_ACK;
			ST_ACK:       if (stat.out_free) state_d = ST_IDLE;
			ST_SCAN_RD:   state_d = stat.scan_at_tail ? ST_RUN_RD : ST_SCAN_CHK;
			ST_SCAN_CHK:  state_d = stop_scan ? ST_RUN_RD : ST_SCAN_RD;
			ST_RUN_RD:    state_d = stat.empty ? ST_TICK_DONE : ST_RUN_CHK;
			ST_RUN_CHK: begin
				case (stat.task_kind)
					TASK_WAIT:    state_d = stat.task_zero ? ST_RUN_RD : ST_TICK_DONE;
					TASK_WAIT_NB: state_d = stat.busy ? ST_TICK_DONE : ST_RUN_RD;
					default:      state_d = stat.task_two ? ST_NIB_HI : ST_NIB_LO;
				endcase
			end
			ST_NIB_HI:    if (stat.out_free) state_d = ST_NIB_LO;
			ST_NIB_LO:    if (stat.out_free) state_d = ST_RUN_RD;
			ST_TICK_DONE: if (stat.out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load_in = s_tvalid;
			ST_DECODE: begin
				cmd.enq_write  = is_enq && !stat.full;
				cmd.flush      = (stat.op == OP_FLUSH);
				cmd.scan_start = (stat.op == OP_TICK);
			end
			ST_ACK: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_ACK;
				cmd.emit_drop = drop_q;
				cmd.emit_last = 1'b1;
			end
			ST_SCAN_RD: begin
				cmd.rd_scan = !stat.scan_at_tail;
				cmd.set_fin = stat.scan_at_tail;
				cmd.fin_val = 1'b1;
			end
			ST_SCAN_CHK: begin
				cmd.set_fin  = stop_scan;
				cmd.fin_val  = 1'b0;
				cmd.scan_adv = !stop_scan;
			end
			ST_RUN_RD: cmd.rd_head = !stat.empty;
			ST_RUN_CHK: begin
				case (stat.task_kind)
					TASK_WAIT: begin
						cmd.head_adv  = stat.task_zero;
						cmd.dec_write = !stat.task_zero;
					end
					TASK_WAIT_NB: cmd.head_adv = !stat.busy;
					default:      cmd.head_adv = 1'b0;
				endcase
			end
			ST_NIB_HI: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_NIBBLE;
				cmd.emit_hi   = 1'b1;
			end
			ST_NIB_LO: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_NIBBLE;
				cmd.head_adv  = stat.out_free;
			end
			ST_TICK_DONE: begin
				cmd.emit      = stat.out_free;
				cmd.emit_kind = KIND_TICK_DONE;
				cmd.emit_last = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/lcd_nibble_command_sequencer_top.sv
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tuser: opcode, to_instruction_reg;
//                                        tdata: value, two_nibbles, busy_flag
// m_*      out        m_tvalid/m_tready  tuser: kind, rs_level; tdata: nibble, dropped,
//                                        queue_empty; tlast: last
//
// Enqueue, flush and unused opcodes pass through transfer, decode and ack.
// A tick runs through transfer and decode, a look-ahead over the queued tasks that finds the
// end-of-tick queue state, a run that carries out the tasks and emits one result per nibble,
// and the tick-finished result.
// Reset clears the indices, controller and output valid flag, not the store. A stalled output
// holds the controller in its emit state; a final result may wait while the next item is taken.
module lcd_nibble_command_sequencer_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // value[15:0], two_nibbles[16], busy_flag[17], zero
	input  logic [3:0]  s_tuser,  // opcode[2:0], to_instruction_reg[3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // nibble[3:0], dropped[4], queue_empty[5], zero
	output logic [2:0]  m_tuser,  // kind[1:0], rs_level[2]
	output logic        m_tlast
);
	import lcdseq_pkg::*;

	lcdseq_cmd_t  cmd;
	lcdseq_stat_t stat;

	// Sequencing controller.
	lcdseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Task store, queue indices and result register.
	lcdseq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
